### src/odq_pkg.sv
// package for the overwriting ring deque: codes, widths and shared types
`default_nettype none
package odq_pkg;

  localparam int DEPTH_DEF = 8;
  localparam int DATA_W    = 32;
  localparam int ACT_W     = 3;
  localparam int POS_W     = 3;
  localparam int STAT_W    = 2;
  localparam int FILL_W    = 4;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH_BACK  = 3'd0,
    ACT_PUSH_FRONT = 3'd1,
    ACT_POP_BACK   = 3'd2,
    ACT_POP_FRONT  = 3'd3,
    ACT_READ       = 3'd4
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_cmd_t;

endpackage
`default_nettype wire

### src/odq_mem.sv
// slot storage with one write port and a registered read port
`default_nettype none
module odq_mem #(
  parameter int DEPTH = odq_pkg::DEPTH_DEF,
  parameter int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                               clk,
  input  wire odq_pkg::mem_cmd_t                  cmd,
  input  wire logic [IW-1:0]                      wr_addr,
  input  wire logic signed [odq_pkg::DATA_W-1:0]  wr_data,
  input  wire logic [IW-1:0]                      rd_addr,
  output logic signed [odq_pkg::DATA_W-1:0]       rd_data
);

  logic signed [odq_pkg::DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

### src/odq_ctrl.sv
// input register, pointer and count update, and result register
`default_nettype none
module odq_ctrl #(
  parameter int DEPTH = odq_pkg::DEPTH_DEF,
  parameter int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  input  wire logic [odq_pkg::ACT_W-1:0]          in_action,
  input  wire logic signed [odq_pkg::DATA_W-1:0]  in_value,
  input  wire logic [odq_pkg::POS_W-1:0]          in_position,
  output odq_pkg::mem_cmd_t                       mem_cmd,
  output logic [IW-1:0]                           wr_addr,
  output logic signed [odq_pkg::DATA_W-1:0]       wr_data,
  output logic [IW-1:0]                           rd_addr,
  output logic                                    out_vld,
  output logic                                    out_rd_ok,
  output logic [odq_pkg::STAT_W-1:0]              out_stat,
  output logic [odq_pkg::FILL_W-1:0]              out_fill
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > odq_pkg::POS_W) ? CW : odq_pkg::POS_W;
  localparam int SW = ((IW > odq_pkg::POS_W) ? IW : odq_pkg::POS_W) + 1;

  function automatic logic [IW-1:0] step_up(input logic [IW-1:0] i);
    step_up = (i == IW'(DEPTH - 1)) ? '0 : i + IW'(1);
  endfunction

  function automatic logic [IW-1:0] step_down(input logic [IW-1:0] i);
    step_down = (i == '0) ? IW'(DEPTH - 1) : i - IW'(1);
  endfunction

  logic                               vld_r;
  odq_pkg::action_t                   act_r;
  logic signed [odq_pkg::DATA_W-1:0]  val_r;
  logic [odq_pkg::POS_W-1:0]          pos_r;

  logic [IW-1:0] front_r, front_nxt;
  logic [IW-1:0] back_r, back_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  logic                      out_vld_r;
  logic                      rd_ok_r, rd_ok_nxt;
  odq_pkg::status_t          stat_r, stat_nxt;
  logic [odq_pkg::FILL_W-1:0] fill_r;

  logic          full;
  logic          empty;
  logic [SW-1:0] sum;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= start;
    end
    if (start) begin
      act_r <= odq_pkg::action_t'(in_action);
      val_r <= in_value;
      pos_r <= in_position;
    end
  end

  assign full  = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign sum   = SW'(front_r) + SW'(pos_r);

  always_comb begin
    front_nxt     = front_r;
    back_nxt      = back_r;
    cnt_nxt       = cnt_r;
    stat_nxt      = odq_pkg::ST_OK;
    rd_ok_nxt     = 1'b0;
    mem_cmd.wr_en = 1'b0;
    mem_cmd.rd_en = 1'b0;
    wr_addr       = back_r;
    wr_data       = val_r;
    rd_addr       = (sum >= SW'(DEPTH)) ? IW'(sum - SW'(DEPTH)) : IW'(sum);
    if (vld_r) begin
      case (act_r)
        odq_pkg::ACT_PUSH_BACK: begin
          mem_cmd.wr_en = 1'b1;
          wr_addr       = back_r;
          back_nxt      = step_up(back_r);
          if (full) begin
            front_nxt = step_up(front_r);
          end else begin
            cnt_nxt = cnt_r + CW'(1);
          end
        end
        odq_pkg::ACT_PUSH_FRONT: begin
          mem_cmd.wr_en = 1'b1;
          wr_addr       = step_down(front_r);
          front_nxt     = step_down(front_r);
          if (full) begin
            back_nxt = step_down(back_r);
          end else begin
            cnt_nxt = cnt_r + CW'(1);
          end
        end
        odq_pkg::ACT_POP_BACK: begin
          if (empty) begin
            stat_nxt = odq_pkg::ST_EMPTY;
          end else begin
            back_nxt = step_down(back_r);
            cnt_nxt  = cnt_r - CW'(1);
          end
        end
        odq_pkg::ACT_POP_FRONT: begin
          if (empty) begin
            stat_nxt = odq_pkg::ST_EMPTY;
          end else begin
            front_nxt = step_up(front_r);
            cnt_nxt   = cnt_r - CW'(1);
          end
        end
        odq_pkg::ACT_READ: begin
          if (PW'(pos_r) >= PW'(cnt_r)) begin
            stat_nxt = odq_pkg::ST_RANGE;
          end else begin
            mem_cmd.rd_en = 1'b1;
            rd_ok_nxt     = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // pointer state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r   <= '0;
      back_r    <= '0;
      cnt_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      front_r   <= front_nxt;
      back_r    <= back_nxt;
      cnt_r     <= cnt_nxt;
      out_vld_r <= vld_r;
    end
    if (vld_r) begin
      rd_ok_r <= rd_ok_nxt;
      stat_r  <= stat_nxt;
      fill_r  <= odq_pkg::FILL_W'(cnt_nxt);
    end
  end

  assign out_vld   = out_vld_r;
  assign out_rd_ok = rd_ok_r;
  assign out_stat  = stat_r;
  assign out_fill  = fill_r;

endmodule
`default_nettype wire

### src/overwriting_ring_deque.sv
// top level of the overwriting ring deque
// a result passes the input register and then the result register, and shows for one cycle
// throughput: one item per cycle, busy is low outside reset, set by one slot access per cycle
// reset: synchronous active-low rst_n empties the deque; slot contents are kept
// the receiver cannot stall, so each result is taken in the cycle it shows
`default_nettype none
module overwriting_ring_deque #(
  parameter int DEPTH = odq_pkg::DEPTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic [odq_pkg::ACT_W-1:0]          in_action,
  input  wire logic signed [odq_pkg::DATA_W-1:0]  in_value,
  input  wire logic [odq_pkg::POS_W-1:0]          in_position,
  output logic                                    out_valid,
  output logic signed [odq_pkg::DATA_W-1:0]       out_read_data,
  output logic [odq_pkg::STAT_W-1:0]              out_status,
  output logic [odq_pkg::FILL_W-1:0]              out_fill_count
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  odq_pkg::mem_cmd_t                 mem_cmd;
  logic [IW-1:0]                     wr_addr;
  logic signed [odq_pkg::DATA_W-1:0] wr_data;
  logic [IW-1:0]                     rd_addr;
  logic signed [odq_pkg::DATA_W-1:0] rd_data;
  logic                              rd_ok;

  odq_ctrl #(.DEPTH(DEPTH), .IW(IW)) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .in_action   (in_action),
    .in_value    (in_value),
    .in_position (in_position),
    .mem_cmd     (mem_cmd),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .rd_addr     (rd_addr),
    .out_vld     (out_valid),
    .out_rd_ok   (rd_ok),
    .out_stat    (out_status),
    .out_fill    (out_fill_count)
  );

  odq_mem #(.DEPTH(DEPTH), .IW(IW)) u_mem (
    .clk     (clk),
    .cmd     (mem_cmd),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // no transfer is taken while reset is held
  assign busy          = ~rst_n;
  assign out_read_data = rd_ok ? rd_data : '0;

endmodule
`default_nettype wire

### src/odq_checker.sv
// port checker for the overwriting ring deque and its bind
`default_nettype none
module odq_checker (
  input wire logic                               clk,
  input wire logic                               rst_n,
  input wire logic                               start,
  input wire logic                               busy,
  input wire logic [odq_pkg::ACT_W-1:0]          in_action,
  input wire logic                               out_valid,
  input wire logic signed [odq_pkg::DATA_W-1:0]  out_read_data,
  input wire logic [odq_pkg::STAT_W-1:0]         out_status,
  input wire logic [odq_pkg::FILL_W-1:0]         out_fill_count
);

  // every start transfer yields exactly one result, through the input register and the result register
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(rst_n, 2) |-> out_valid == $past(start && !busy, 2))
    else $error("result strobe does not follow start transfer");

  a_err_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != odq_pkg::ST_OK |-> out_read_data == '0)
    else $error("error result carries data");

  a_empty_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == odq_pkg::ST_EMPTY |-> out_fill_count == '0)
    else $error("pop on empty with nonzero fill");

  a_range_is_read: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(rst_n, 2) && out_valid && out_status == odq_pkg::ST_RANGE
    |-> $past(in_action, 2) == odq_pkg::ACT_READ)
    else $error("range error on a non-read transfer");

endmodule

bind overwriting_ring_deque odq_checker u_odq_checker (.*);
`default_nettype wire

### tb/sv/tb.sv
// self-checking testbench for the overwriting ring deque: directed and random actions
`timescale 1ns / 100ps
module tb;

  localparam int RING = odq_pkg::DEPTH_DEF;
  localparam int RIW = $clog2(RING);
  localparam int CYCLE_LIMIT = 100000;
  localparam int RANDOM_PER_PHASE = 250;
  localparam logic [odq_pkg::ACT_W-1:0] ACT_SPARE_LO = 3'd5;
  localparam logic [odq_pkg::ACT_W-1:0] ACT_SPARE_MID = 3'd6;
  localparam logic [odq_pkg::ACT_W-1:0] ACT_SPARE_HI = 3'd7;

  typedef struct {
    logic [odq_pkg::ACT_W-1:0]         action;
    logic signed [odq_pkg::DATA_W-1:0] value;
    logic [odq_pkg::POS_W-1:0]         position;
  } request_t;

  typedef struct {
    logic signed [odq_pkg::DATA_W-1:0] read_data;
    odq_pkg::status_t                  status;
    logic [odq_pkg::FILL_W-1:0]        fill_count;
  } outcome_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [odq_pkg::ACT_W-1:0] in_action = '0;
  logic signed [odq_pkg::DATA_W-1:0] in_value = '0;
  logic [odq_pkg::POS_W-1:0] in_position = '0;
  logic out_valid;
  logic signed [odq_pkg::DATA_W-1:0] out_read_data;
  logic [odq_pkg::STAT_W-1:0] out_status;
  logic [odq_pkg::FILL_W-1:0] out_fill_count;

  request_t pending_reqs[$];
  outcome_t expected_outcomes[$];
  request_t next_req;
  int idle_pct = 29;
  int errors = 0;
  int cycles = 0;

  logic signed [odq_pkg::DATA_W-1:0] ring_slots [RING];
  int unsigned head_ptr = 0;
  int unsigned tail_ptr = 0;
  int unsigned held = 0;

  overwriting_ring_deque dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_action(in_action),
    .in_value(in_value),
    .in_position(in_position),
    .out_valid(out_valid),
    .out_read_data(out_read_data),
    .out_status(out_status),
    .out_fill_count(out_fill_count)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic int unsigned ring_up(int unsigned i);
    return (i + 1 >= RING) ? 0 : i + 1;
  endfunction

  function automatic int unsigned ring_down(int unsigned i);
    return (i == 0) ? RING - 1 : i - 1;
  endfunction

  function automatic outcome_t apply_action(logic [odq_pkg::ACT_W-1:0] act,
                                            logic signed [odq_pkg::DATA_W-1:0] val,
                                            logic [odq_pkg::POS_W-1:0] pos);
    outcome_t r;
    r.read_data = '0;
    r.status = odq_pkg::ST_OK;
    case (act)
      odq_pkg::ACT_PUSH_BACK: begin
        ring_slots[RIW'(tail_ptr)] = val;
        tail_ptr = ring_up(tail_ptr);
        if (held >= RING) head_ptr = ring_up(head_ptr);
        else held++;
      end
      odq_pkg::ACT_PUSH_FRONT: begin
        head_ptr = ring_down(head_ptr);
        ring_slots[RIW'(head_ptr)] = val;
        if (held >= RING) tail_ptr = ring_down(tail_ptr);
        else held++;
      end
      odq_pkg::ACT_POP_BACK, odq_pkg::ACT_POP_FRONT: begin
        if (held == 0) begin
          r.status = odq_pkg::ST_EMPTY;
        end else begin
          if (act == odq_pkg::ACT_POP_BACK) tail_ptr = ring_down(tail_ptr);
          else head_ptr = ring_up(head_ptr);
          held--;
        end
      end
      odq_pkg::ACT_READ: begin
        if (pos >= held) r.status = odq_pkg::ST_RANGE;
        else r.read_data = ring_slots[RIW'((head_ptr + pos) % RING)];
      end
      default: ;
    endcase
    r.fill_count = held[odq_pkg::FILL_W-1:0];
    return r;
  endfunction

  task automatic queue_req(logic [odq_pkg::ACT_W-1:0] act,
                           logic signed [odq_pkg::DATA_W-1:0] val,
                           logic [odq_pkg::POS_W-1:0] pos);
    request_t q;
    q.action = act;
    q.value = val;
    q.position = pos;
    pending_reqs.insert(pending_reqs.size(), q);
  endtask

  function automatic logic signed [odq_pkg::DATA_W-1:0] random_word();
    case ($urandom_range(7))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  // chunks lean toward filling, draining or a mix so full and empty are both reached
  task automatic add_random_reqs(int n);
    int lean;
    int roll;
    int push_cut;
    int pop_cut;
    int read_cut;
    logic [odq_pkg::ACT_W-1:0] act;
    lean = 0;
    push_cut = 0;
    pop_cut = 0;
    read_cut = 0;
    for (int k = 0; k < n; k++) begin
      if (k % 25 == 0) begin
        lean = $urandom_range(2);
        case (lean)
          0: begin push_cut = 70; pop_cut = 80; read_cut = 95; end
          1: begin push_cut = 15; pop_cut = 75; read_cut = 95; end
          default: begin push_cut = 35; pop_cut = 65; read_cut = 95; end
        endcase
      end
      roll = $urandom_range(99);
      if (roll < push_cut) begin
        act = $urandom_range(1) ? odq_pkg::ACT_PUSH_FRONT : odq_pkg::ACT_PUSH_BACK;
      end else if (roll < pop_cut) begin
        act = $urandom_range(1) ? odq_pkg::ACT_POP_FRONT : odq_pkg::ACT_POP_BACK;
      end else if (roll < read_cut) begin
        act = odq_pkg::ACT_READ;
      end else begin
        act = odq_pkg::ACT_W'($urandom_range(ACT_SPARE_HI, ACT_SPARE_LO));
      end
      queue_req(act, random_word(), odq_pkg::POS_W'($urandom_range(7)));
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (pending_reqs.size() != 0 || start || expected_outcomes.size() != 0) @(negedge clk);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_outcomes.insert(expected_outcomes.size(),
                                 apply_action(in_action, in_value, in_position));
      end
      if (!(start && busy)) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= idle_pct) begin
          next_req = pending_reqs[0];
          pending_reqs.delete(0);
          start <= 1'b1;
          in_action <= next_req.action;
          in_value <= next_req.value;
          in_position <= next_req.position;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_outcomes.size() == 0) begin
        $display("%0t: result with none expected: data %0d status %0d fill %0d",
                 $time, out_read_data, out_status, out_fill_count);
        errors++;
      end else begin
        if (out_read_data !== expected_outcomes[0].read_data) begin
          $display("%0t: read_data expected %0d actual %0d",
                   $time, expected_outcomes[0].read_data, out_read_data);
          errors++;
        end
        if (out_status !== expected_outcomes[0].status) begin
          $display("%0t: status expected %0d actual %0d",
                   $time, expected_outcomes[0].status, out_status);
          errors++;
        end
        if (out_fill_count !== expected_outcomes[0].fill_count) begin
          $display("%0t: fill_count expected %0d actual %0d",
                   $time, expected_outcomes[0].fill_count, out_fill_count);
          errors++;
        end
        expected_outcomes.delete(0);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // empty buffer errors and spare codes, then a push at each end and reads by position
    queue_req(odq_pkg::ACT_POP_BACK, 32'sd5, 3'd0);
    queue_req(odq_pkg::ACT_POP_FRONT, 32'sd5, 3'd0);
    queue_req(odq_pkg::ACT_READ, '0, 3'd0);
    queue_req(ACT_SPARE_LO, 32'sd9, 3'd0);
    queue_req(ACT_SPARE_HI, '1, 3'd7);
    queue_req(odq_pkg::ACT_PUSH_BACK, 32'sh7fff_ffff, 3'd0);
    queue_req(odq_pkg::ACT_PUSH_FRONT, 32'sh8000_0000, 3'd7);
    queue_req(odq_pkg::ACT_READ, '0, 3'd0);
    queue_req(odq_pkg::ACT_READ, '0, 3'd1);
    queue_req(odq_pkg::ACT_READ, '0, 3'd2);
    // fill to capacity, then overwrite from both ends
    for (int k = 0; k < 6; k++) queue_req(odq_pkg::ACT_PUSH_BACK, k - 1, 3'd0);
    queue_req(odq_pkg::ACT_PUSH_BACK, 32'sd55, 3'd0);
    queue_req(odq_pkg::ACT_PUSH_FRONT, 32'sd66, 3'd0);
    queue_req(odq_pkg::ACT_READ, '0, 3'd0);
    queue_req(odq_pkg::ACT_READ, '0, 3'd7);
    queue_req(ACT_SPARE_MID, '0, 3'd3);
    queue_req(odq_pkg::ACT_POP_BACK, '0, 3'd0);
    queue_req(odq_pkg::ACT_POP_FRONT, '0, 3'd0);
    queue_req(odq_pkg::ACT_READ, '0, 3'd7);
    queue_req(odq_pkg::ACT_POP_FRONT, '0, 3'd0);

    add_random_reqs(RANDOM_PER_PHASE);
    wait_drained();
    idle_pct = 63;
    add_random_reqs(RANDOM_PER_PHASE);
    wait_drained();
    idle_pct = 0;
    add_random_reqs(RANDOM_PER_PHASE);
    wait_drained();

    repeat (8) @(posedge clk);
    if (expected_outcomes.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, expected_outcomes.size());
      errors++;
    end
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
